// ===== rtl/core/spiral_phase_mask_rotator_defines.svh =====
// Assertion macros for the spiral phase mask rotator.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SPIRAL_PHASE_MASK_ROTATOR_DEFINES_SVH
`define SPIRAL_PHASE_MASK_ROTATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPM_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("spm assertion failed");
`define SPM_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("spm reset assertion failed");
`else
`define SPM_ASSERT(lbl, prop)
`define SPM_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/spm_pkg.sv =====
// Shared constants for the spiral phase mask rotator.
// No dependencies; imported by every module of the block.
`default_nettype none
package spm_pkg;
	localparam int CORDIC_STEPS = 24;
	localparam int GUARD_BITS = 8;
	localparam int CHARGE_W = 16;
	localparam int SECTOR_W = 8;
	localparam int OFFSET_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int APPLIED_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 2'd2;

	// 1/gain of the 24 step CORDIC in Q20
	localparam logic signed [20:0] INV_GAIN_Q20 = 21'sd636751;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679839, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};
endpackage
`default_nettype wire

// ===== rtl/core/spiral_phase_mask_rotator.sv =====
// Spiral phase mask rotator, top level.
// Pipeline from input beat to output beat: 24 angle cells, PHASE_WIDTH + 23 divider cells,
// 24 rotation cells and 8 other stages.
// Throughput: one beat per cycle; the whole pipe advances together and holds on output stall.
// Reset: arst_n clears the config registers and every valid bit; payload is not reset.
`default_nettype none
`include "spiral_phase_mask_rotator_defines.svh"
module spiral_phase_mask_rotator import spm_pkg::*; #(
	parameter int SAMPLE_WIDTH = 18,
	parameter int COORD_WIDTH = 10,
	parameter int PHASE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_DATA_W-1:0]          cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]  offset_x,
	input  wire logic signed [COORD_WIDTH-1:0]  offset_y,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_re,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_im,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      rotated_re,
	output logic signed [SAMPLE_WIDTH-1:0]      rotated_im,
	output logic [APPLIED_W-1:0]                applied_phase
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int CW = COORD_WIDTH;
	localparam int PW = PHASE_WIDTH;
	localparam int XW = CW + 19;        // vectoring datapath, offsets scaled by 2^16
	localparam int RW = SW + 11;        // rotation datapath, guard bits plus CORDIC growth
	localparam int AW = PW + 28;        // sector numerator
	localparam int DW = PW + 23;        // biased dividend, always non-negative
	localparam int MW = RW + 21;        // gain product
	localparam int VW = MW - 28;        // rounded result before saturation
	localparam int VSIDE = 2 * SW + 1;
	localparam int DSIDE = 2 * SW + PW + 1;
	localparam logic [PW-1:0] HALF = PW'(1) << (PW - 1);
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// ---------------------------------------------------------------
	// Config registers. The user must write them only while the pipe is
	// empty (the block does not enforce it), so every stage reads them live.
	// ---------------------------------------------------------------
	logic signed [CHARGE_W-1:0] charge_q;
	logic [SECTOR_W-1:0] sector_count_q;
	logic [OFFSET_W-1:0] phase_offset_q;
	logic [PW-1:0] off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
			sector_count_q <= '0;
			phase_offset_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHARGE: charge_q <= cfg_data[CHARGE_W-1:0];
				REG_SECTOR_COUNT: sector_count_q <= cfg_data[SECTOR_W-1:0];
				REG_PHASE_OFFSET: phase_offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// offset rescaled to PW bits of a turn
	generate
		if (PW >= OFFSET_W) begin : g_off_wide
			assign off = PW'(phase_offset_q) << (PW - OFFSET_W);
		end else begin : g_off_narrow
			assign off = phase_offset_q[OFFSET_W-1 -: PW];
		end
	endgenerate

	// Global advance: the pipe moves whenever the output register is free
	// or being emptied in this cycle.
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	assign en = !vld_s8 || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: capture the beat.
	// ---------------------------------------------------------------
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic signed [SW-1:0] re_s1, im_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= offset_x;
			dy_s1 <= offset_y;
			re_s1 <= sample_re;
			im_s1 <= sample_im;
		end
	end

	// Vector set-up: scale by 2^16, fold the left half plane onto the right
	// with a half-turn start angle.
	logic signed [XW-1:0] x_sc, y_sc;
	logic signed [XW-1:0] vx [CORDIC_STEPS+1];
	logic signed [XW-1:0] vy [CORDIC_STEPS+1];
	logic [31:0] vz [CORDIC_STEPS+1];
	logic [VSIDE-1:0] vside [CORDIC_STEPS+1];
	logic vvld [CORDIC_STEPS+1];

	always_comb begin
		x_sc = XW'(dx_s1) <<< 16;
		y_sc = XW'(dy_s1) <<< 16;
		vx[0] = dx_s1[CW-1] ? -x_sc : x_sc;
		vy[0] = dx_s1[CW-1] ? -y_sc : y_sc;
		vz[0] = dx_s1[CW-1] ? 32'h8000_0000 : 32'h0;
		vside[0] = {re_s1, im_s1, (dx_s1 == '0) && (dy_s1 == '0)};
		vvld[0] = vld_s1;
	end

	generate
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
			spm_vec_cell #(.STEP(i), .XW(XW), .SIDE_W(VSIDE)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_in(vvld[i]), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
				.side_in(vside[i]),
				.vld_out(vvld[i+1]), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]),
				.side_out(vside[i+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Stage 2: round the angle to PW bits, signed in (-1/2, 1/2] turn.
	// ---------------------------------------------------------------
	logic [PW+1:0] z_rnd;
	logic [PW-1:0] zp;
	logic signed [PW:0] ang_s2;
	logic signed [SW-1:0] re_s2, im_s2;

	assign z_rnd = {1'b0, vz[CORDIC_STEPS][31 -: PW+1]} + (PW+2)'(1);
	assign zp = z_rnd[PW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vvld[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// centre cell has no angle
			ang_s2 <= vside[CORDIC_STEPS][0] ? '0 : {(zp > HALF), zp};
			re_s2 <= vside[CORDIC_STEPS][VSIDE-1 -: SW];
			im_s2 <= vside[CORDIC_STEPS][SW:1];
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: charge times angle; sector index from the shifted angle.
	// ---------------------------------------------------------------
	logic [PW:0] s_sum;
	logic [PW+8:0] s_prod;
	logic signed [PW+16:0] prod_s3;
	logic [8:0] idx_s3;
	logic signed [SW-1:0] re_s3, im_s3;

	always_comb begin
		s_sum = (PW+1)'(ang_s2) + (PW+1)'(HALF) + (PW+1)'(off);
		s_prod = (PW+9)'(s_sum) * (PW+9)'(sector_count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= (PW+17)'(ang_s2) * (PW+17)'(charge_q);
			idx_s3 <= s_prod[PW+8:PW];
			re_s3 <= re_s2;
			im_s3 <= im_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: continuous phase; wrapped sector index times charge.
	// ---------------------------------------------------------------
	logic [PW+7:0] prod_rnd;
	logic [PW-1:0] ph_c;
	logic [8:0] idx_w;
	logic signed [10:0] sec_d;
	logic signed [26:0] m_s4;
	logic [PW-1:0] ph_alt_s4;
	logic sel_div_s4;
	logic signed [SW-1:0] re_s4, im_s4;

	always_comb begin
		prod_rnd = prod_s3[PW+7:0] + (PW+8)'(128);
		ph_c = prod_rnd[PW+7:8] + off;
		// index runs below twice the count, so one subtraction wraps it
		idx_w = (idx_s3 > {1'b0, sector_count_q}) ? idx_s3 - {1'b0, sector_count_q} : idx_s3;
		sec_d = $signed({1'b0, idx_w, 1'b0}) - $signed({3'b0, sector_count_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= 27'(sec_d) * 27'(charge_q);
			ph_alt_s4 <= (charge_q == '0) ? off : ph_c;
			sel_div_s4 <= (charge_q != '0) && (sector_count_q != '0);
			re_s4 <= re_s3;
			im_s4 <= im_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: dividend. floor((m*2^PW + 256n) / 512n) is taken as
	// floor(floor(. / 512) / n); a bias of n*2^(PW+15) keeps it positive
	// and leaves the quotient unchanged modulo 2^PW.
	// ---------------------------------------------------------------
	logic signed [AW-1:0] num_a, num_b, num_p;
	logic [DW-1:0] dvd_s5;
	logic [PW-1:0] ph_alt_s5;
	logic sel_div_s5;
	logic signed [SW-1:0] re_s5, im_s5;

	always_comb begin
		num_a = (AW'(m_s4) <<< PW) + $signed(AW'({sector_count_q, 8'b0}));
		num_b = num_a >>> 9;
		num_p = num_b + $signed(AW'(sector_count_q) << (PW + 15));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s5 <= num_p[DW-1:0];
			ph_alt_s5 <= ph_alt_s4;
			sel_div_s5 <= sel_div_s4;
			re_s5 <= re_s4;
			im_s5 <= im_s4;
		end
	end

	// divider chain, one quotient bit per cell
	logic [SECTOR_W-1:0] drem [DW+1];
	logic [DW-1:0] ddvd [DW+1];
	logic [PW-1:0] dquo [DW+1];
	logic [DSIDE-1:0] dside [DW+1];
	logic dvld [DW+1];

	assign drem[0] = '0;
	assign ddvd[0] = dvd_s5;
	assign dquo[0] = '0;
	assign dside[0] = {re_s5, im_s5, ph_alt_s5, sel_div_s5};
	assign dvld[0] = vld_s5;

	generate
		for (genvar k = 0; k < DW; k++) begin : g_div
			spm_div_cell #(.DW(DW), .PW(PW), .SIDE_W(DSIDE)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_in(dvld[k]),
				.divisor(sector_count_q),
				.rem_in(drem[k]), .dvd_in(ddvd[k]), .quo_in(dquo[k]), .side_in(dside[k]),
				.vld_out(dvld[k+1]), .rem_out(drem[k+1]), .dvd_out(ddvd[k+1]),
				.quo_out(dquo[k+1]), .side_out(dside[k+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Stage 6: pick the phase, pre-rotate by the nearest quarter turn.
	// ---------------------------------------------------------------
	logic [DSIDE-1:0] dtail;
	logic [PW-1:0] phase;
	logic [31:0] zr, zq, rr;
	logic [1:0] quad;
	logic signed [RW-1:0] xb, yb;
	logic signed [RW-1:0] x_s6, y_s6;
	logic [31:0] r_s6;
	logic [PW-1:0] phase_s6;

	always_comb begin
		dtail = dside[DW];
		phase = dtail[0] ? dquo[DW] : dtail[PW:1];
		zr = {phase, {(32 - PW){1'b0}}};
		zq = zr + 32'h2000_0000;
		quad = zq[31:30];
		rr = zr - {quad, 30'b0};
		xb = RW'(signed'(dtail[DSIDE-1 -: SW])) <<< GUARD_BITS;
		yb = RW'(signed'(dtail[PW+SW:PW+1])) <<< GUARD_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= dvld[DW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad)
				QUAD_0: begin
					x_s6 <= xb;
					y_s6 <= yb;
				end
				QUAD_1: begin
					x_s6 <= -yb;
					y_s6 <= xb;
				end
				QUAD_2: begin
					x_s6 <= -xb;
					y_s6 <= -yb;
				end
				QUAD_3: begin
					x_s6 <= yb;
					y_s6 <= -xb;
				end
				default: begin
					x_s6 <= xb;
					y_s6 <= yb;
				end
			endcase
			r_s6 <= rr;
			phase_s6 <= phase;
		end
	end

	// rotation chain
	logic signed [RW-1:0] rx [CORDIC_STEPS+1];
	logic signed [RW-1:0] ry [CORDIC_STEPS+1];
	logic [31:0] rz [CORDIC_STEPS+1];
	logic [PW-1:0] rside [CORDIC_STEPS+1];
	logic rvld [CORDIC_STEPS+1];

	assign rx[0] = x_s6;
	assign ry[0] = y_s6;
	assign rz[0] = r_s6;
	assign rside[0] = phase_s6;
	assign rvld[0] = vld_s6;

	generate
		for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
			spm_rot_cell #(.STEP(j), .RW(RW), .SIDE_W(PW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_in(rvld[j]), .x_in(rx[j]), .y_in(ry[j]), .r_in(rz[j]),
				.side_in(rside[j]),
				.vld_out(rvld[j+1]), .x_out(rx[j+1]), .y_out(ry[j+1]), .r_out(rz[j+1]),
				.side_out(rside[j+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Stage 7: gain compensation.
	// ---------------------------------------------------------------
	logic signed [MW-1:0] px_s7, py_s7;
	logic [PW-1:0] phase_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= rvld[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7 <= MW'(rx[CORDIC_STEPS]) * MW'(INV_GAIN_Q20);
			py_s7 <= MW'(ry[CORDIC_STEPS]) * MW'(INV_GAIN_Q20);
			phase_s7 <= rside[CORDIC_STEPS];
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: round half up, saturate, output register.
	// ---------------------------------------------------------------
	localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);
	logic signed [MW-1:0] px_r, py_r;
	logic signed [VW-1:0] vx_r, vy_r;
	logic signed [SW-1:0] sat_x, sat_y;
	logic signed [SW-1:0] re_s8, im_s8;
	logic [PW-1:0] phase_s8;

	always_comb begin
		px_r = (px_s7 + (MW'(1) <<< 27)) >>> 28;
		py_r = (py_s7 + (MW'(1) <<< 27)) >>> 28;
		vx_r = px_r[VW-1:0];
		vy_r = py_r[VW-1:0];
		if (vx_r > SAT_HI) sat_x = SAT_HI[SW-1:0];
		else if (vx_r < SAT_LO) sat_x = SAT_LO[SW-1:0];
		else sat_x = vx_r[SW-1:0];
		if (vy_r > SAT_HI) sat_y = SAT_HI[SW-1:0];
		else if (vy_r < SAT_LO) sat_y = SAT_LO[SW-1:0];
		else sat_y = vy_r[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_s8 <= sat_x;
			im_s8 <= sat_y;
			phase_s8 <= phase_s7;
		end
	end

	assign rotated_re = re_s8;
	assign rotated_im = im_s8;

	// reported phase is always 16 bits of a turn
	generate
		if (PW >= APPLIED_W) begin : g_ph_wide
			assign applied_phase = phase_s8[PW-1 -: APPLIED_W];
		end else begin : g_ph_narrow
			assign applied_phase = APPLIED_W'(phase_s8) << (APPLIED_W - PW);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`SPM_ASSERT_RST(a_reset_empties, !arst_n |=> !out_valid)
	`SPM_ASSERT(a_stall_holds_pipe, (!en && vld_s6) |=> vld_s6 && $stable(phase_s6))
	`SPM_ASSERT(a_div_sel_cfg, (vld_s5 && sel_div_s5) |-> (charge_q != '0 && sector_count_q != '0))
endmodule
`default_nettype wire

// ===== rtl/core/spm_vec_cell.sv =====
// One vectoring CORDIC step: rotates (x, y) towards the x axis, accumulates angle.
// Depends on spm_pkg for the arctan table.
`default_nettype none
module spm_vec_cell import spm_pkg::*; #(
	parameter int STEP = 0,
	parameter int XW = 29,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_in,
	input  wire logic signed [XW-1:0] x_in,
	input  wire logic signed [XW-1:0] y_in,
	input  wire logic [31:0]       z_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   vld_out,
	output logic signed [XW-1:0]   x_out,
	output logic signed [XW-1:0]   y_out,
	output logic [31:0]            z_out,
	output logic [SIDE_W-1:0]      side_out
);
	logic signed [XW-1:0] xs, ys, x_nx, y_nx;
	logic [31:0] z_nx;

	always_comb begin
		xs = x_in >>> STEP;
		ys = y_in >>> STEP;
		if (y_in[XW-1]) begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - ATAN_TURNS[STEP];
		end else begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + ATAN_TURNS[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= x_nx;
			y_out <= y_nx;
			z_out <= z_nx;
			side_out <= side_in;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/spm_div_cell.sv =====
// One restoring division step by the sector count; keeps the low quotient bits.
// Depends on spm_pkg for the sector width.
`default_nettype none
module spm_div_cell import spm_pkg::*; #(
	parameter int DW = 39,
	parameter int PW = 16,
	parameter int SIDE_W = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_in,
	input  wire logic [SECTOR_W-1:0] divisor,
	input  wire logic [SECTOR_W-1:0] rem_in,
	input  wire logic [DW-1:0]       dvd_in,
	input  wire logic [PW-1:0]       quo_in,
	input  wire logic [SIDE_W-1:0]   side_in,
	output logic                     vld_out,
	output logic [SECTOR_W-1:0]      rem_out,
	output logic [DW-1:0]            dvd_out,
	output logic [PW-1:0]            quo_out,
	output logic [SIDE_W-1:0]        side_out
);
	logic [SECTOR_W:0] trial, diff;
	logic ge;

	always_comb begin
		trial = {rem_in, dvd_in[DW-1]};
		diff = trial - {1'b0, divisor};
		ge = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[SECTOR_W-1:0] : trial[SECTOR_W-1:0];
			dvd_out <= {dvd_in[DW-2:0], 1'b0};
			quo_out <= {quo_in[PW-2:0], ge};
			side_out <= side_in;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/spm_rot_cell.sv =====
// One rotation CORDIC step: turns (x, y) by the sign of the residual angle.
// Depends on spm_pkg for the arctan table.
`default_nettype none
module spm_rot_cell import spm_pkg::*; #(
	parameter int STEP = 0,
	parameter int RW = 29,
	parameter int SIDE_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_in,
	input  wire logic signed [RW-1:0] x_in,
	input  wire logic signed [RW-1:0] y_in,
	input  wire logic [31:0]          r_in,
	input  wire logic [SIDE_W-1:0]    side_in,
	output logic                      vld_out,
	output logic signed [RW-1:0]      x_out,
	output logic signed [RW-1:0]      y_out,
	output logic [31:0]               r_out,
	output logic [SIDE_W-1:0]         side_out
);
	logic signed [RW-1:0] xs, ys, x_nx, y_nx;
	logic [31:0] r_nx;

	always_comb begin
		xs = x_in >>> STEP;
		ys = y_in >>> STEP;
		if (r_in[31]) begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			r_nx = r_in + ATAN_TURNS[STEP];
		end else begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			r_nx = r_in - ATAN_TURNS[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= x_nx;
			y_out <= y_nx;
			r_out <= r_nx;
			side_out <= side_in;
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for spiral_phase_mask_rotator: random and corner-case cells are
// streamed through several register settings and checked against a bit-exact predictor.
// Depends on spm_pkg and the RTL of the block only.
module tb_top import spm_pkg::*;;

	localparam int SW = 18;
	localparam int CW = 10;
	localparam int PW = 16;
	localparam int LATENCY = 79 + PW;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_STALL = 400;
	// index 3 decodes to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
	} cell_t;

	typedef struct packed {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
		logic [APPLIED_W-1:0] ph;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CHARGE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] offset_x = '0;
	logic signed [CW-1:0] offset_y = '0;
	logic signed [SW-1:0] sample_re = '0;
	logic signed [SW-1:0] sample_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SW-1:0] rotated_re;
	logic signed [SW-1:0] rotated_im;
	logic [APPLIED_W-1:0] applied_phase;

	spiral_phase_mask_rotator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.offset_x(offset_x), .offset_y(offset_y),
		.sample_re(sample_re), .sample_im(sample_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.rotated_re(rotated_re), .rotated_im(rotated_im),
		.applied_phase(applied_phase)
	);

	always #10 clk = ~clk;

	// bench copy of the register file
	longint mask_charge = 0;
	longint mask_sectors = 0;
	longint mask_offset = 0;

	cell_t cells_pending[$];
	rotated_t rotations_due[$];
	int errors = 0;
	int cells_sent = 0;
	int beats_checked = 0;
	int settings_run = 0;
	bit gaps_on = 1'b1;
	bit long_stall_done = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;

	function automatic longint sat_sample(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	// bit-exact model of one cell: polar angle, mask phase, CORDIC rotation
	function automatic rotated_t predict_rotation(cell_t c);
		longint x, y, nx, ny, ang, ph, n, s, idx, num, den, r;
		bit [31:0] z, q, rr, zq;
		bit [15:0] phase;
		rotated_t res;
		ang = 0;
		if (mask_charge == 0) begin
			phase = mask_offset[15:0];
		end else begin
			if (c.ox != 0 || c.oy != 0) begin
				x = longint'(c.ox) * 65536;
				y = longint'(c.oy) * 65536;
				z = 32'h0;
				// left half plane: flip and start from a half turn
				if (x < 0) begin
					x = -x;
					y = -y;
					z = 32'h8000_0000;
				end
				for (int i = 0; i < CORDIC_STEPS; i++) begin
					if (y >= 0) begin
						nx = x + (y >>> i);
						ny = y - (x >>> i);
						z = z + ATAN_TURNS[i];
					end else begin
						nx = x - (y >>> i);
						ny = y + (x >>> i);
						z = z - ATAN_TURNS[i];
					end
					x = nx;
					y = ny;
				end
				ang = (((longint'(z) >> 15) + 1) >> 1) & 65535;
				if (ang > 32768) ang -= 65536;
			end
			if (mask_sectors > 0) begin
				n = mask_sectors;
				s = ang + 32768 + mask_offset;
				idx = (s * n) >>> 16;
				// an index equal to the count is kept
				if (idx > n) idx = ((idx - 1) % n) + 1;
				den = 512 * n;
				num = (2 * idx - n) * mask_charge * 65536;
				ph = floor_div(num + den / 2, den);
			end else begin
				ph = ((ang * mask_charge + 128) >>> 8) + mask_offset;
			end
			phase = ph[15:0];
		end
		z = {phase, 16'h0};
		zq = z + 32'h2000_0000;
		q = (zq >> 30) & 32'd3;
		rr = z - (q << 30);
		x = longint'(c.re) * 256;
		y = longint'(c.im) * 256;
		case (q)
			32'd1: begin nx = -y; y = x; x = nx; end
			32'd2: begin x = -x; y = -y; end
			32'd3: begin nx = y; y = -x; x = nx; end
			default: ;
		endcase
		r = longint'(signed'(rr));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				r -= ATAN_TURNS[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				r += ATAN_TURNS[i];
			end
			x = nx;
			y = ny;
		end
		nx = sat_sample((x * 636751 + (longint'(1) <<< 27)) >>> 28);
		ny = sat_sample((y * 636751 + (longint'(1) <<< 27)) >>> 28);
		res.re = nx[SW-1:0];
		res.im = ny[SW-1:0];
		res.ph = phase;
		return res;
	endfunction

	// Sender: predicts on each accepted beat, then offers the next pending cell.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				rotations_due.push_back(predict_rotation(
					'{ox: offset_x, oy: offset_y, re: sample_re, im: sample_im}));
				cells_sent++;
			end
			if (in_valid && !in_ready) begin
				// hold the beat
			end else if (cells_pending.size() > 0 &&
					!(gaps_on && $urandom_range(99) < 13)) begin
				cell_t c;
				c = cells_pending.pop_front();
				offset_x <= c.ox;
				offset_y <= c.oy;
				sample_re <= c.re;
				sample_im <= c.im;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each output beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (rotations_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected output beat re=%0d im=%0d phase=%h",
						$time, rotated_re, rotated_im, applied_phase);
				end else begin
					rotated_t e;
					e = rotations_due.pop_front();
					if (e.re !== rotated_re) begin
						errors++;
						$display("%0t: rotated_re expected %0d actual %0d",
							$time, e.re, rotated_re);
					end
					if (e.im !== rotated_im) begin
						errors++;
						$display("%0t: rotated_im expected %0d actual %0d",
							$time, e.im, rotated_im);
					end
					if (e.ph !== applied_phase) begin
						errors++;
						$display("%0t: applied_phase expected %h actual %h",
							$time, e.ph, applied_phase);
					end
				end
				beats_checked++;
			end
			// one long back-pressure episode, so the pipe fills and in_ready drops
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!long_stall_done && beats_checked == 200) begin
				long_stall_done <= 1'b1;
				stall_left <= LONG_STALL;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(99) < 13);
			end
		end
	end

	// Watchdog on cycles with no beat accepted on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				rotations_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_CHARGE: mask_charge = longint'(signed'(val));
			REG_SECTOR_COUNT: mask_sectors = longint'(val[7:0]);
			REG_PHASE_OFFSET: mask_offset = longint'(val);
			default: ;
		endcase
	endtask

	// wait until the pipe is drained and quiet
	task automatic drain();
		while (cells_pending.size() > 0 || in_valid || rotations_due.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic add_cell(int ox, int oy, int re, int im);
		cell_t c;
		c.ox = CW'(ox);
		c.oy = CW'(oy);
		c.re = SW'(re);
		c.im = SW'(im);
		cells_pending.push_back(c);
	endtask

	task automatic add_corner_cells();
		add_cell(0, 0, 1000, -1000);          // centre cell
		add_cell(-512, -512, 131071, 131071);
		add_cell(511, 511, -131072, -131072);
		add_cell(-512, 511, 131071, -131072);
		add_cell(511, -512, -131072, 131071);
		add_cell(-5, 0, 50000, 20000);        // half turn, sector index wrap edge
		add_cell(0, 7, 0, 0);                 // quarter turn
		add_cell(0, -7, -1, 1);
		add_cell(3, 0, 77777, -3);
		add_cell(1, 1, 131071, 0);
	endtask

	task automatic add_random_cells(int count);
		int ox, oy, re, im;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(3) == 0) begin
				ox = $urandom_range(8) - 4;
				oy = $urandom_range(8) - 4;
			end else begin
				ox = $urandom_range(1023) - 512;
				oy = $urandom_range(1023) - 512;
			end
			if ($urandom_range(7) == 0) begin
				re = $urandom_range(1) ? 131071 : -131072;
				im = $urandom_range(1) ? 131071 : -131072;
			end else begin
				re = $urandom_range(262143) - 131072;
				im = $urandom_range(262143) - 131072;
			end
			add_cell(ox, oy, re, im);
		end
	endtask

	task automatic run_setting(logic [15:0] chg, logic [7:0] sec, logic [15:0] off,
			int count);
		drain();
		write_reg(REG_CHARGE, chg);
		write_reg(REG_SECTOR_COUNT, sec);
		write_reg(REG_PHASE_OFFSET, off);
		settings_run++;
		add_corner_cells();
		add_random_cells(count);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// reset values: zero charge, constant phase
		add_corner_cells();
		add_random_cells(40);
		run_setting(16'h0000, 8'd0, 16'h4000, 60);
		run_setting(16'h0100, 8'd0, 16'h0000, 180);   // long receiver stall lands here
		run_setting(16'h8000, 8'd0, 16'hFFFF, 100);
		@(posedge clk);
		gaps_on <= 1'b0;                               // back-to-back stretch
		run_setting(16'h7FFF, 8'd255, 16'h0000, 120);
		run_setting(16'h0100, 8'd1, 16'h0000, 80);
		run_setting(16'h0200, 8'd4, 16'h8000, 100);
		drain();
		gaps_on <= 1'b1;
		run_setting(16'hFF00, 8'd255, 16'hFFFF, 100);
		// a write to the unused index must leave the registers alone
		drain();
		write_reg(REG_NONE, 16'hFFFF);
		add_random_cells(40);
		for (int k = 0; k < 4; k++)
			run_setting(16'($urandom), 8'($urandom), 16'($urandom), 90);
		drain();
		$display("Checked %0d beats over %0d register settings (constant, continuous and",
			beats_checked, settings_run + 1);
		$display("sectored phase), with random gaps, one long output stall and a gap-free run.");
		if (errors == 0 && rotations_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
